// ===== rtl/cci_pkg.sv =====
// Shared widths, status codes, transaction types and helpers for the circle intersection core.
package cci_pkg;

    // Coordinate width and the derived working widths
    localparam int CW = 32;          // signed coordinate
    localparam int RW = CW - 1;      // unsigned radius / min distance
    localparam int DW = CW + 1;      // centre difference and distance
    localparam int HW = 2 * CW;      // saturating intermediate domain
    localparam int WW = 4 * CW;      // exact product domain

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_FAR   = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    localparam logic [RW-1:0] MIN_DIST_RESET = RW'(65);

    typedef struct packed {
        logic signed [CW-1:0] center_a_x;
        logic signed [CW-1:0] center_a_y;
        logic        [RW-1:0] radius_a;
        logic signed [CW-1:0] center_b_x;
        logic signed [CW-1:0] center_b_y;
        logic        [RW-1:0] radius_b;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic        [1:0]    status;
    } t_out;

    // Classified job handed from front to back
    typedef struct packed {
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [DW-1:0] dx;
        logic [DW-1:0] dy;
        logic [RW-1:0] ra;
        logic [RW-1:0] rb;
        logic [DW-1:0] d;
        logic [1:0]    status;
    } t_job;

    // Magnitude of a two's complement centre difference
    function automatic logic [DW-1:0] mag_d(input logic [DW-1:0] x);
        mag_d = x[DW-1] ? (~x + DW'(1)) : x;
    endfunction

endpackage

// ===== rtl/cci_stream_if.sv =====
// Valid/ready stream interface carrying one payload struct per transaction.
interface cci_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/circle_circle_intersection_core.sv =====
// Top level of the circle intersection core: config register, front, job queue, back.
//
// Usage: i_in (valid/ready) takes one transaction holding two circles (centre, radius,
// Q16.16); o_out (valid/ready) returns one transaction with two points and a status
// (found, too far, too close). i_cfg_we/i_cfg_data write the minimum centre distance;
// write it only while the core is idle.
// Flow: the front finds the distance with a 33-step root and classifies it; an error
// result then passes through the job queue and the back to the output register. A found
// result also runs in the back: one 64-step divide and four 128-step divides on a shared
// radix-2 divider, a 64-step root, and multiplies built from CW x CW partial products.
// The back takes a new job only once it has returned to its idle state.
// The input register, the two-entry job queue and the output register let the front
// accept and classify new items while the back works or the receiver stalls; a
// stalled receiver holds o_out and back-pressure reaches i_in once the queue and input register fill.
// Reset (synchronous, active low) empties all stages and sets the minimum
// distance to 65.
module circle_circle_intersection_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [cci_pkg::RW-1:0] i_cfg_data,
    cci_stream_if.sink             i_in,
    cci_stream_if.source           o_out
);
    import cci_pkg::*;

    logic [RW-1:0] r_min_dist;

    cci_stream_if #(.T(t_job)) job_w ();
    cci_stream_if #(.T(t_job)) job_q ();

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= MIN_DIST_RESET;
        end else if (i_cfg_we) begin
            r_min_dist <= i_cfg_data;
        end
    end

    cci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_dist (r_min_dist),
        .i_in       (i_in),
        .o_job      (job_w)
    );

    cci_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_w),
        .o_job   (job_q)
    );

    cci_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_q),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // A job classified as found has a nonzero distance within the radius sum and minimum
    a_found_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_q.valid && job_q.data.status == ST_FOUND) |->
        (job_q.data.d != '0 && job_q.data.d >= DW'(r_min_dist) &&
         job_q.data.d <= DW'({1'b0, job_q.data.ra} + {1'b0, job_q.data.rb})))
        else $error("found job violates distance classification");

    // Error results carry zero points
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.status == ST_FAR || o_out.data.status == ST_CLOSE)) |->
        (o_out.data.first_x == '0 && o_out.data.first_y == '0 &&
         o_out.data.second_x == '0 && o_out.data.second_y == '0))
        else $error("error result with nonzero points");

    // The input register holds one transaction until the front takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while holding register full");
`endif
endmodule

// ===== rtl/cci_sqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module cci_sqrt #(
    parameter int OUT_W = 33,
    parameter int IN_W  = 66
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IN_W-1:0]  i_radicand,
    output logic             o_done,
    output logic [OUT_W-1:0] o_root
);
    localparam int RMW = OUT_W + 2;
    localparam int CNW = (OUT_W > 1) ? $clog2(OUT_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNW-1:0]   r_cnt;
    logic [IN_W-1:0]  r_rad;
    logic [RMW-1:0]   r_rem;
    logic [OUT_W-1:0] r_root;

    logic [RMW+1:0]   sh;
    logic [RMW+1:0]   trial;
    logic             ge;
    logic [RMW+1:0]   diff;

    // One digit: bring down two radicand bits, try root*4+1
    always_comb begin
        sh    = {r_rem, r_rad[IN_W-1 -: 2]};
        trial = (RMW+2)'({r_root, 2'b01});
        ge    = sh >= trial;
        diff  = sh - trial;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(OUT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNW'(1);
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? diff[RMW-1:0] : sh[RMW-1:0];
            r_root <= {r_root[OUT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== rtl/cci_front.sv =====
// Front end: input skid register, centre distance and far/close classification.
module cci_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [cci_pkg::RW-1:0] i_min_dist,
    cci_stream_if.sink            i_in,
    cci_stream_if.source          o_job
);
    import cci_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQ   = 2'd1;
    localparam logic [1:0] F_ROOT = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]      r_state;
    logic            r_buf_v;
    t_in             r_buf;
    t_job            r_job;

    logic            take;
    logic            in_acc;
    logic [DW-1:0]   mag_x;
    logic [DW-1:0]   mag_y;
    logic [2*DW-1:0] sq_x;
    logic [2*DW-1:0] sq_y;
    logic [2*DW-1:0] sum_sq;
    logic            sq_done;
    logic [DW-1:0]   root;
    logic [CW-1:0]   r_sum;
    logic            far;
    logic            close;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_buf_v;
    assign take       = r_buf_v && (r_state == F_IDLE);

    // Input holding register, frees up as soon as the worker takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_v <= 1'b0;
        end else if (in_acc) begin
            r_buf_v <= 1'b1;
        end else if (take) begin
            r_buf_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf <= i_in.data;
        end
    end

    // Sum of squares of the centre difference
    always_comb begin
        mag_x  = mag_d(r_job.dx);
        mag_y  = mag_d(r_job.dy);
        sq_x   = mag_x * mag_x;
        sq_y   = mag_y * mag_y;
        sum_sq = sq_x + sq_y;
    end

    cci_sqrt #(.OUT_W(DW), .IN_W(2*DW)) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == F_SQ),
        .i_radicand (sum_sq),
        .o_done     (sq_done),
        .o_root     (root)
    );

    // Distance test first, then the minimum distance test
    always_comb begin
        far   = root > DW'(r_sum);
        close = (root < DW'(i_min_dist)) || (root == '0);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (take) r_state <= F_SQ;
                end
                F_SQ: begin
                    r_state <= F_ROOT;
                end
                F_ROOT: begin
                    if (sq_done) r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (o_job.ready) r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Job payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job.ax <= r_buf.center_a_x;
            r_job.ay <= r_buf.center_a_y;
            r_job.ra <= r_buf.radius_a;
            r_job.rb <= r_buf.radius_b;
            r_job.dx <= {r_buf.center_b_x[CW-1], r_buf.center_b_x}
                      - {r_buf.center_a_x[CW-1], r_buf.center_a_x};
            r_job.dy <= {r_buf.center_b_y[CW-1], r_buf.center_b_y}
                      - {r_buf.center_a_y[CW-1], r_buf.center_a_y};
            r_sum    <= {1'b0, r_buf.radius_a} + {1'b0, r_buf.radius_b};
        end
        if (r_state == F_ROOT && sq_done) begin
            r_job.d <= root;
            if (far) begin
                r_job.status <= ST_FAR;
            end else if (close) begin
                r_job.status <= ST_CLOSE;
            end else begin
                r_job.status <= ST_FOUND;
            end
        end
    end

    assign o_job.valid = (r_state == F_PUSH);
    assign o_job.data  = r_job;
endmodule

// ===== rtl/cci_fifo.sv =====
// Two-entry job queue between front and back.
module cci_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cci_stream_if.sink   i_job,
    cci_stream_if.source o_job
);
    import cci_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign i_job.ready = (r_cnt != 2'd2);
    assign o_job.valid = (r_cnt != 2'd0);
    assign o_job.data  = r_mem[r_rp];
    assign wr          = i_job.valid && i_job.ready;
    assign rd          = o_job.valid && o_job.ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            if (wr && !rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job.data;
    end
endmodule

// ===== rtl/cci_back.sv =====
// Back end: chord foot, half chord and point arithmetic over a shared multiplier and divider.
module cci_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cci_stream_if.sink   i_job,
    cci_stream_if.source o_out
);
    import cci_pkg::*;

    localparam int DCW = $clog2(WW);

    localparam logic [3:0] B_IDLE   = 4'd0;
    localparam logic [3:0] B_SQR    = 4'd1;
    localparam logic [3:0] B_DIV1   = 4'd2;
    localparam logic [3:0] B_DIV    = 4'd3;
    localparam logic [3:0] B_M      = 4'd4;
    localparam logic [3:0] B_MUL    = 4'd5;
    localparam logic [3:0] B_VV     = 4'd6;
    localparam logic [3:0] B_ROOT   = 4'd7;
    localparam logic [3:0] B_KSET   = 4'd8;
    localparam logic [3:0] B_KDIV   = 4'd9;
    localparam logic [3:0] B_KSTORE = 4'd10;
    localparam logic [3:0] B_FOOT   = 4'd11;
    localparam logic [3:0] B_EMIT   = 4'd12;

    function automatic logic [HW+1:0] sgn_q(input logic [HW-1:0] q, input logic neg);
        sgn_q = neg ? (~{2'b00, q} + (HW+2)'(1)) : {2'b00, q};
    endfunction

    function automatic logic [HW+1:0] ext_h(input logic [HW-1:0] x);
        ext_h = {{2{x[HW-1]}}, x};
    endfunction

    // Saturate to the signed 2*CW-bit range
    function automatic logic [HW-1:0] sat_h(input logic [HW+1:0] x);
        if (x[HW+1:HW-1] == 3'b000 || x[HW+1:HW-1] == 3'b111) begin
            sat_h = x[HW-1:0];
        end else if (x[HW+1]) begin
            sat_h = {1'b1, {(HW-1){1'b0}}};
        end else begin
            sat_h = {1'b0, {(HW-1){1'b1}}};
        end
    endfunction

    // Clamp to the signed coordinate range
    function automatic logic [CW-1:0] clamp_c(input logic [HW-1:0] x);
        if ((&x[HW-1:CW-1]) || !(|x[HW-1:CW-1])) begin
            clamp_c = x[CW-1:0];
        end else if (x[HW-1]) begin
            clamp_c = {1'b1, {(CW-1){1'b0}}};
        end else begin
            clamp_c = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    logic [3:0]     r_state;
    logic [3:0]     r_ret;
    t_job           r_jb;
    logic [HW-1:0]  r_ra2;
    logic [HW-1:0]  r_rb2;
    logic           r_pneg;
    logic [WW-1:0]  r_num;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [HW-1:0]  r_quo;
    logic [DCW-1:0] r_dcnt;
    logic [HW-1:0]  r_ma;
    logic [HW-1:0]  r_mb;
    logic [WW-1:0]  r_acc;
    logic [1:0]     r_mcnt;
    logic           r_mneg;
    logic [HW-1:0]  r_mm;
    logic [HW-1:0]  r_v;
    logic [1:0]     r_k;
    logic [HW-1:0]  r_q [4];
    logic [3:0]     r_qneg;
    logic [HW-1:0]  r_fx;
    logic [HW-1:0]  r_fy;
    logic           r_out_v;
    t_out           r_out;
    t_out           n_out;

    logic           take;
    logic           emit;
    logic [DW:0]    div_sh;
    logic [DW:0]    div_diff;
    logic           div_ge;
    logic [1:0]     mul_sh;
    logic [HW-1:0]  mul_pp;
    logic [WW-1:0]  mul_add;
    logic [HW-1:0]  diff_ab;
    logic [HW:0]    m_wide;
    logic [HW:0]    m_neg;
    logic [HW-1:0]  mm;
    logic [WW-1:0]  vv;
    logic           sq_done;
    logic [HW-1:0]  root;
    logic [DW-1:0]  mag_x;
    logic [DW-1:0]  mag_y;
    logic [HW-1:0]  k_a;
    logic [HW-1:0]  k_b;
    logic           k_neg;

    assign take        = i_job.valid && (r_state == B_IDLE);
    assign i_job.ready = (r_state == B_IDLE);
    assign emit        = (r_state == B_EMIT) && (!r_out_v || o_out.ready);

    // Restoring divider step
    always_comb begin
        div_sh   = {r_rem, r_num[WW-1]};
        div_ge   = div_sh >= {1'b0, r_den};
        div_diff = div_sh - {1'b0, r_den};
    end

    // One CW x CW partial product per cycle
    always_comb begin
        mul_sh  = {1'b0, r_mcnt[0]} + {1'b0, r_mcnt[1]};
        mul_pp  = r_ma[r_mcnt[0]*CW +: CW] * r_mb[r_mcnt[1]*CW +: CW];
        mul_add = WW'(mul_pp) << (mul_sh * CW);
    end

    // Chord foot distance m = d/2 +- |ra^2 - rb^2| / 2d
    always_comb begin
        diff_ab = (r_ra2 < r_rb2) ? (r_rb2 - r_ra2) : (r_ra2 - r_rb2);
        m_wide  = r_pneg ? ((HW+1)'(r_jb.d >> 1) - (HW+1)'(r_quo))
                         : ((HW+1)'(r_jb.d >> 1) + (HW+1)'(r_quo));
        m_neg   = ~m_wide + (HW+1)'(1);
        mm      = m_wide[HW] ? m_neg[HW-1:0] : m_wide[HW-1:0];
        vv      = (WW'(r_ra2) >= r_acc) ? (WW'(r_ra2) - r_acc) : (r_acc - WW'(r_ra2));
        mag_x   = mag_d(r_jb.dx);
        mag_y   = mag_d(r_jb.dy);
    end

    // Operands of the four scaled products
    always_comb begin
        case (r_k)
            2'd0: begin
                k_a   = HW'(mag_x);
                k_b   = r_mm;
                k_neg = r_jb.dx[DW-1] ^ r_mneg;
            end
            2'd1: begin
                k_a   = HW'(mag_y);
                k_b   = r_mm;
                k_neg = r_jb.dy[DW-1] ^ r_mneg;
            end
            2'd2: begin
                k_a   = HW'(mag_y);
                k_b   = r_v;
                k_neg = r_jb.dy[DW-1];
            end
            default: begin
                k_a   = HW'(mag_x);
                k_b   = r_v;
                k_neg = r_jb.dx[DW-1];
            end
        endcase
    end

    cci_sqrt #(.OUT_W(HW), .IN_W(WW)) u_chord (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == B_VV),
        .i_radicand (vv),
        .o_done     (sq_done),
        .o_root     (root)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (take) begin
                        r_state <= (i_job.data.status == ST_FOUND) ? B_SQR : B_EMIT;
                    end
                end
                B_SQR:    r_state <= B_DIV1;
                B_DIV1:   r_state <= B_DIV;
                B_DIV: begin
                    if (r_dcnt == '0) r_state <= r_ret;
                end
                B_M:      r_state <= B_MUL;
                B_MUL: begin
                    if (r_mcnt == 2'd3) r_state <= r_ret;
                end
                B_VV:     r_state <= B_ROOT;
                B_ROOT: begin
                    if (sq_done) r_state <= B_KSET;
                end
                B_KSET:   r_state <= B_MUL;
                B_KDIV:   r_state <= B_DIV;
                B_KSTORE: r_state <= (r_k == 2'd3) ? B_FOOT : B_KSET;
                B_FOOT:   r_state <= B_EMIT;
                B_EMIT: begin
                    if (emit) r_state <= B_IDLE;
                end
                default:  r_state <= B_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (take) r_jb <= i_job.data;
            end
            B_SQR: begin
                r_ra2 <= HW'(r_jb.ra) * HW'(r_jb.ra);
                r_rb2 <= HW'(r_jb.rb) * HW'(r_jb.rb);
            end
            B_DIV1: begin
                r_pneg <= r_ra2 < r_rb2;
                r_num  <= {diff_ab, {HW{1'b0}}};
                r_rem  <= '0;
                r_den  <= {r_jb.d[DW-2:0], 1'b0};
                r_dcnt <= DCW'(HW - 1);
                r_ret  <= B_M;
            end
            B_DIV: begin
                r_num  <= r_num << 1;
                r_rem  <= div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
                r_quo  <= {r_quo[HW-2:0], div_ge};
                r_dcnt <= r_dcnt - DCW'(1);
            end
            B_M: begin
                r_mneg <= m_wide[HW];
                r_mm   <= mm;
                r_ma   <= mm;
                r_mb   <= mm;
                r_acc  <= '0;
                r_mcnt <= 2'd0;
                r_ret  <= B_VV;
            end
            B_MUL: begin
                r_acc  <= r_acc + mul_add;
                r_mcnt <= r_mcnt + 2'd1;
            end
            B_ROOT: begin
                if (sq_done) begin
                    r_v <= root;
                    r_k <= 2'd0;
                end
            end
            B_KSET: begin
                r_ma         <= k_a;
                r_mb         <= k_b;
                r_qneg[r_k]  <= k_neg;
                r_acc        <= '0;
                r_mcnt       <= 2'd0;
                r_ret        <= B_KDIV;
            end
            B_KDIV: begin
                r_num  <= r_acc;
                r_rem  <= '0;
                r_den  <= r_jb.d;
                r_dcnt <= DCW'(WW - 1);
                r_ret  <= B_KSTORE;
            end
            B_KSTORE: begin
                r_q[r_k] <= r_quo;
                r_k      <= r_k + 2'd1;
            end
            B_FOOT: begin
                r_fx <= sat_h({{(HW+2-CW){r_jb.ax[CW-1]}}, r_jb.ax} + sgn_q(r_q[0], r_qneg[0]));
                r_fy <= sat_h({{(HW+2-CW){r_jb.ay[CW-1]}}, r_jb.ay} + sgn_q(r_q[1], r_qneg[1]));
            end
            default: begin
            end
        endcase
    end

    // Result assembly: error results carry zero points
    always_comb begin
        n_out.status = r_jb.status;
        if (r_jb.status == ST_FOUND) begin
            n_out.first_x  = clamp_c(sat_h(ext_h(r_fx) - sgn_q(r_q[2], r_qneg[2])));
            n_out.first_y  = clamp_c(sat_h(ext_h(r_fy) + sgn_q(r_q[3], r_qneg[3])));
            n_out.second_x = clamp_c(sat_h(ext_h(r_fx) + sgn_q(r_q[2], r_qneg[2])));
            n_out.second_y = clamp_c(sat_h(ext_h(r_fy) - sgn_q(r_q[3], r_qneg[3])));
        end else begin
            n_out.first_x  = '0;
            n_out.first_y  = '0;
            n_out.second_x = '0;
            n_out.second_y = '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= n_out;
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the circle intersection core: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb_top;
    import cci_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int N_RANDOM     = 1030;
    localparam longint S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN  = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [RW-1:0]   i_cfg_data;

    cci_stream_if #(.T(t_in))  in_if ();
    cci_stream_if #(.T(t_out)) out_if ();

    circle_circle_intersection_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Directed stimulus row; expected result typed in only where obvious
    typedef struct {
        t_in  circles;
        bit   typed;
        t_out result;
    } t_row;

    t_out          pending_points[$];
    logic [RW-1:0] min_dist;
    int            n_errors = 0;
    int            n_cycles = 0;
    bit            long_hold_go;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, floor
    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    // Signed 64-bit saturation of a magnitude
    function automatic longint sat_mag(input bit neg, input logic [127:0] m);
        if (m >= 128'h8000_0000_0000_0000) return neg ? S64_MIN : S64_MAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sd0 && s[64] != s[63]) return S64_MAX;
        if (s[64] != s[63]) return S64_MIN;
        return longint'(s[63:0]);
    endfunction

    function automatic longint sub_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint scaled_quot(input bit neg, input logic [63:0] a,
                                           input logic [63:0] b, input logic [63:0] den);
        return sat_mag(neg, ({64'd0, a} * {64'd0, b}) / {64'd0, den});
    endfunction

    function automatic logic [CW-1:0] clamp_coord(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (v < -longint'(32'sh8000_0000) - 0 && v < -64'sd2147483648) return 32'h8000_0000;
        return v[CW-1:0];
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        logic [63:0] u;
        u = v;
        return v < 0 ? -u : u;
    endfunction

    // Intersection points of two circles, bit exact
    function automatic t_out intersect_points(input t_in c);
        t_out         r;
        longint       ax, ay, dx, dy, m, fx, fy, px, py;
        logic [63:0]  mdx, mdy, d, ra, rb, mm, v;
        logic [127:0] ra2, rb2, diff, m2, vv;
        bit           pneg;
        r  = '0;
        ax = longint'(c.center_a_x);
        ay = longint'(c.center_a_y);
        dx = longint'(c.center_b_x) - ax;
        dy = longint'(c.center_b_y) - ay;
        ra = 64'(c.radius_a);
        rb = 64'(c.radius_b);
        mdx = abs64(dx);
        mdy = abs64(dy);
        d = floor_root({64'd0, mdx} * {64'd0, mdx} + {64'd0, mdy} * {64'd0, mdy});
        if (d > ra + rb) begin
            r.status = ST_FAR;
            return r;
        end
        if (d < 64'(min_dist) || d == 0) begin
            r.status = ST_CLOSE;
            return r;
        end
        ra2  = {64'd0, ra} * {64'd0, ra};
        rb2  = {64'd0, rb} * {64'd0, rb};
        pneg = ra2 < rb2;
        diff = pneg ? rb2 - ra2 : ra2 - rb2;
        m    = add_sat(longint'(d >> 1), sat_mag(pneg, diff / {63'd0, d, 1'b0}));
        mm   = abs64(m);
        m2   = {64'd0, mm} * {64'd0, mm};
        vv   = (ra2 >= m2) ? ra2 - m2 : m2 - ra2;
        v    = floor_root(vv);
        fx = add_sat(ax, scaled_quot((dx < 0) != (m < 0), mdx, mm, d));
        fy = add_sat(ay, scaled_quot((dy < 0) != (m < 0), mdy, mm, d));
        px = scaled_quot(dy < 0, mdy, v, d);
        py = scaled_quot(dx < 0, mdx, v, d);
        r.first_x  = clamp_coord(sub_sat(fx, px));
        r.first_y  = clamp_coord(add_sat(fy, py));
        r.second_x = clamp_coord(add_sat(fx, px));
        r.second_y = clamp_coord(sub_sat(fy, py));
        r.status   = ST_FOUND;
        return r;
    endfunction

    // Receiver: stall pattern in phases, plus one long hold-off
    int rx_mode, rx_left, hold_cnt;
    bit hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_mode <= 0;
            rx_left <= 0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (long_hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 3000;
            out_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_if.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(20, 400);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: begin
                    out_if.ready <= 1'b1;
                end
                1: begin
                    out_if.ready <= $urandom_range(0, 1);
                end
                default: begin
                    out_if.ready <= ($urandom_range(0, 9) != 0);
                end
            endcase
        end
    end

    // Result checker: oldest expectation first
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_points.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result %p", out_if.data);
            end else begin
                want = pending_points.pop_front();
                if (out_if.data !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: mismatch exp %p act %p", want, out_if.data);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    int burst_left;

    // Offer one transaction and hold it until taken; gaps come between bursts
    task automatic send_circles(input t_in c, input bit typed, input t_out want);
        int gap;
        in_if.valid <= 1'b1;
        in_if.data  <= c;
        do @(posedge i_clk); while (!in_if.ready);
        pending_points.push_back(typed ? want : intersect_points(c));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Pause the sender until every result is back, then let the core settle
    task automatic drain();
        in_if.valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_min_dist(input logic [RW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        min_dist    = value;
        @(posedge i_clk);
    endtask

    // Two circles that mostly cross or nest, at a random scale
    function automatic t_in crossing_circles();
        t_in c;
        int  sh;
        logic signed [31:0] dx, dy;
        sh = $urandom_range(2, 29);
        c.center_a_x = $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
        c.center_a_y = $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
        dx = $signed($urandom() & ((32'd1 << sh) - 1)) - $signed(32'd1 << (sh - 1));
        dy = $signed($urandom() & ((32'd1 << sh) - 1)) - $signed(32'd1 << (sh - 1));
        c.center_b_x = c.center_a_x + dx;
        c.center_b_y = c.center_a_y + dy;
        c.radius_a = RW'($urandom() & ((32'd1 << sh) - 1));
        c.radius_b = RW'($urandom() & ((32'd1 << sh) - 1));
        return c;
    endfunction

    function automatic t_in noise_circles();
        t_in c;
        c.center_a_x = $urandom();
        c.center_a_y = $urandom();
        c.radius_a   = RW'($urandom());
        c.center_b_x = $urandom();
        c.center_b_y = $urandom();
        c.radius_b   = RW'($urandom());
        return c;
    endfunction

    function automatic t_row mk_row(input logic signed [31:0] ax, input logic signed [31:0] ay,
                                    input logic [RW-1:0] ra, input logic signed [31:0] bx,
                                    input logic signed [31:0] by, input logic [RW-1:0] rb,
                                    input bit typed, input logic [1:0] status);
        t_row r;
        r.circles = '{ax, ay, ra, bx, by, rb};
        r.typed   = typed;
        r.result  = '0;
        r.result.status = status;
        return r;
    endfunction

    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;
    localparam logic [RW-1:0]      RMAX = '1;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    t_row directed[$];
    t_out none;
    logic [RW-1:0] phase_min[5];

    initial begin
        none = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        long_hold_go = 1'b0;
        min_dist    = MIN_DIST_RESET;
        burst_left  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, error codes, tangent, nested, saturation
        directed.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, ST_CLOSE));
        directed.push_back(mk_row(PMIN, PMIN, 0, PMAX, PMAX, 0, 1, ST_FAR));
        directed.push_back(mk_row(PMAX, PMAX, RMAX, PMAX, PMAX, RMAX, 1, ST_CLOSE));
        directed.push_back(mk_row(0, 0, 1000, 64, 0, 1000, 1, ST_CLOSE));
        directed.push_back(mk_row(0, 0, 1000, 65, 0, 1000, 0, ST_FOUND));
        directed.push_back(mk_row(0, 0, 10, 65, 0, 10, 1, ST_FAR));
        directed.push_back(mk_row(0, 0, RW'(ONE), ONE, 0, RW'(ONE), 0, ST_FOUND));
        directed.push_back(mk_row(0, 0, RW'(ONE / 2), ONE, 0, RW'(ONE / 2), 0, ST_FOUND));
        directed.push_back(mk_row(0, 0, RW'(10 * ONE), ONE, 0, RW'(ONE), 0, ST_FOUND));
        directed.push_back(mk_row(0, 0, RW'(ONE), 0, ONE, RW'(10 * ONE), 0, ST_FOUND));
        directed.push_back(mk_row(PMIN, PMIN, RMAX, PMAX, PMAX, RMAX, 0, ST_FOUND));
        directed.push_back(mk_row(PMAX, PMIN, RMAX, PMIN, PMAX, RMAX, 0, ST_FOUND));
        directed.push_back(mk_row(PMIN, 0, RMAX, PMAX, 0, 0, 0, ST_FOUND));
        directed.push_back(mk_row(0, PMAX, 0, 0, PMIN, RMAX, 0, ST_FOUND));
        directed.push_back(mk_row(-3 * ONE, 2 * ONE, RW'(4 * ONE), ONE, -ONE, RW'(3 * ONE),
                                  0, ST_FOUND));
        directed.push_back(mk_row(5, -7, RMAX, -9, 11, 3, 0, ST_FOUND));
        foreach (directed[i])
            send_circles(directed[i].circles, directed[i].typed, directed[i].result);
        drain();

        // Min distance 0: coincident centres still too close
        write_min_dist('0);
        send_circles('{0, 0, 5, 0, 0, 5}, 1, '{0, 0, 0, 0, ST_CLOSE});
        send_circles('{0, 0, 5, 1, 0, 5}, 0, none);
        drain();

        // Random phases over several minimum distances, the extremes among them
        phase_min[0] = '0;
        phase_min[1] = RMAX;
        phase_min[2] = RW'($urandom());
        phase_min[3] = RW'(32'd1 << $urandom_range(4, 20));
        phase_min[4] = MIN_DIST_RESET;
        for (int p = 0; p < 5; p++) begin
            write_min_dist(phase_min[p]);
            if (p == 2) long_hold_go = 1'b1;
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if ($urandom_range(0, 9) < 8)
                    send_circles(crossing_circles(), 0, none);
                else
                    send_circles(noise_circles(), 0, none);
            end
            drain();
        end

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== circle_circle_intersection_core.f =====
rtl/cci_pkg.sv
rtl/cci_stream_if.sv
rtl/cci_sqrt.sv
rtl/cci_front.sv
rtl/cci_fifo.sv
rtl/cci_back.sv
rtl/circle_circle_intersection_core.sv
verif/tb_top.sv
